/* hdl/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;
    localparam int MAX_TIMERS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam int QDEPTH = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] KIND_ADDED = 3'd0;
    localparam logic [2:0] KIND_FULL = 3'd1;
    localparam logic [2:0] KIND_REMOVED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_EXPIRED = 3'd4;
    localparam logic [2:0] KIND_IDLE = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] interval_ms;
        logic        repeat_flag;
        logic [31:0] user_tag;
        logic [31:0] target_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [31:0]        timer_id;
        logic [47:0]        deadline;
        logic [31:0]        tag_out;
        logic signed [32:0] time_remaining;
        logic               last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_EMIT, ST_REM, ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* hdl/dtq_front.sv */
// ----------------------------------------------------------------------------
// dtq_front
// Accepts requests, drops unknown operations and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_front
    import dtq_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic q_valid,
    input  wire  q_ready,
    output cmd_t q_cmd
);
    cmd_t q_mem [QDEPTH];
    logic [0:0] wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    // a full queue stalls the input; unknown operations are swallowed
    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push = in_valid && in_ready && (in_cmd.operation != OP_UNUSED);
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

/* hdl/dtq_back.sv */
// ----------------------------------------------------------------------------
// dtq_back
// Timer table and sequencer: carries out add, remove and tick requests.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_back
    import dtq_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output logic out_valid,
    input  wire  out_ready,
    output res_t out_res
);
    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [MAX_TIMERS-1:0] fired_reg, fired_next;
    logic [47:0] dl_reg [MAX_TIMERS];
    logic [31:0] iv_reg [MAX_TIMERS];
    logic        per_reg [MAX_TIMERS];
    logic [31:0] id_reg [MAX_TIMERS];
    logic [31:0] tg_reg [MAX_TIMERS];
    logic [47:0] now_reg, now_next;
    logic [31:0] nid_reg, nid_next;
    state_t      st_reg, st_next;
    cmd_t        cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic        hit_reg, hit_next;
    logic [SLOT_W-1:0] pick_reg, pick_next;
    logic [RES_W-1:0]  n_reg, n_next;
    logic        any_reg, any_next;
    logic [47:0] best_reg, best_next;
    res_t        res_reg, res_next;
    logic        ov_reg, ov_next;
    logic        pend_reg, pend_next;
    logic        rem_done_reg, rem_done_next;
    logic        more_reg, more_next;
    logic        wr_en, wr_dl_only;
    logic [SLOT_W-1:0] wr_slot;
    logic [47:0] wr_dl;
    logic [SLOT_W-1:0] cur;
    logic        cand;
    logic        better;
    logic [47:0] gap;
    logic        is_tick;
    logic [47:0] eff_dl;
    logic        eff_ok;
    logic        fin;

    assign cur = idx_reg[SLOT_W-1:0];
    assign q_ready = (st_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_res = res_reg;
    assign cand = valid_reg[cur] && !fired_reg[cur] && (dl_reg[cur] <= now_reg);
    assign better = !hit_reg || (dl_reg[cur] < dl_reg[pick_reg]) ||
                    ((dl_reg[cur] == dl_reg[pick_reg]) && (id_reg[cur] < id_reg[pick_reg]));
    assign gap = best_reg - now_reg;
    // during a tick a slot still due will fire in this tick: take its final deadline
    assign is_tick = (cmd_reg.operation == OP_TICK);
    assign eff_dl = (is_tick && cand) ? now_reg + 48'(iv_reg[cur]) : dl_reg[cur];
    assign eff_ok = valid_reg[cur] && !(is_tick && cand && !per_reg[cur]);
    assign fin = rem_done_reg || !more_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (q_valid && q_ready) begin
                st_next = (q_cmd.operation == OP_TICK) ? ST_SCAN : ST_SCAN;
            end
            ST_SCAN: if (idx_reg == CNT_W'(MAX_TIMERS - 1)) begin
                st_next = ST_EMIT;
            end
            ST_EMIT: if (!ov_reg) begin
                st_next = ST_REM;
            end
            ST_REM: if (idx_reg == CNT_W'(MAX_TIMERS - 1)) begin
                st_next = ST_OUT;
            end
            ST_OUT: if (!ov_reg) begin
                st_next = (fin) ? ST_IDLE : ST_SCAN;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        valid_next = valid_reg;
        fired_next = fired_reg;
        now_next = now_reg;
        nid_next = nid_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        pick_next = pick_reg;
        n_next = n_reg;
        any_next = any_reg;
        best_next = best_reg;
        res_next = res_reg;
        ov_next = ov_reg && !out_ready;
        pend_next = pend_reg;
        rem_done_next = rem_done_reg;
        more_next = more_reg;
        wr_en = 1'b0;
        wr_dl_only = 1'b0;
        wr_slot = pick_reg;
        wr_dl = '0;
        case (st_reg)
            ST_IDLE: begin
                if (q_valid && q_ready) begin
                    cmd_next = q_cmd;
                    idx_next = '0;
                    hit_next = 1'b0;
                    n_next = '0;
                    fired_next = '0;
                    rem_done_next = 1'b0;
                    if (q_cmd.operation == OP_TICK) begin
                        now_next = now_reg + 48'd1;
                    end
                end
            end
            ST_SCAN: begin
                // search one slot a cycle: first free, first match or earliest due slot
                case (cmd_reg.operation)
                    OP_ADD: if (!hit_reg && !valid_reg[cur]) begin
                        hit_next = 1'b1;
                        pick_next = cur;
                    end
                    OP_REMOVE: if (!hit_reg && valid_reg[cur] &&
                                   id_reg[cur] == cmd_reg.target_id) begin
                        hit_next = 1'b1;
                        pick_next = cur;
                    end
                    default: if (cand && better) begin
                        hit_next = 1'b1;
                        pick_next = cur;
                    end
                endcase
                idx_next = idx_reg + 1'b1;
            end
            ST_EMIT: begin
                if (!ov_reg) begin
                    res_next = '0;
                    pend_next = 1'b1;
                    case (cmd_reg.operation)
                        OP_ADD: begin
                            if (hit_reg) begin
                                res_next.result_kind = KIND_ADDED;
                                res_next.timer_id = nid_reg + 32'd1;
                                res_next.deadline = now_reg + 48'(cmd_reg.interval_ms);
                                nid_next = nid_reg + 32'd1;
                                valid_next[pick_reg] = 1'b1;
                                wr_en = 1'b1;
                                wr_dl = now_reg + 48'(cmd_reg.interval_ms);
                            end else begin
                                res_next.result_kind = KIND_FULL;
                            end
                            rem_done_next = 1'b1;
                        end
                        OP_REMOVE: begin
                            res_next.timer_id = cmd_reg.target_id;
                            if (hit_reg) begin
                                res_next.result_kind = KIND_REMOVED;
                                valid_next[pick_reg] = 1'b0;
                            end else begin
                                res_next.result_kind = KIND_NOT_FOUND;
                            end
                            rem_done_next = 1'b1;
                        end
                        default: begin
                            if (hit_reg) begin
                                res_next.result_kind = KIND_EXPIRED;
                                res_next.timer_id = id_reg[pick_reg];
                                res_next.deadline = dl_reg[pick_reg];
                                res_next.tag_out = tg_reg[pick_reg];
                                fired_next[pick_reg] = 1'b1;
                                if (per_reg[pick_reg]) begin
                                    wr_dl_only = 1'b1;
                                    wr_dl = now_reg + 48'(iv_reg[pick_reg]);
                                end else begin
                                    valid_next[pick_reg] = 1'b0;
                                end
                                n_next = n_reg + 1'b1;
                                rem_done_next = (n_reg + 1'b1 == RES_W'(MAX_RESULTS));
                            end else if (n_reg == '0) begin
                                res_next.result_kind = KIND_IDLE;
                                rem_done_next = 1'b1;
                            end else begin
                                pend_next = 1'b0;
                                rem_done_next = 1'b1;
                            end
                        end
                    endcase
                    idx_next = '0;
                    any_next = 1'b0;
                    more_next = 1'b0;
                end
            end
            ST_REM: begin
                // minimum final deadline over valid slots; note any slot still due
                if (eff_ok && (!any_reg || eff_dl < best_reg)) begin
                    any_next = 1'b1;
                    best_next = eff_dl;
                end
                if (is_tick && cand) begin
                    more_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_OUT: begin
                if (!ov_reg) begin
                    // release the held result with the time left after the whole request
                    if (pend_reg) begin
                        ov_next = 1'b1;
                        pend_next = 1'b0;
                    end
                    res_next.last = fin;
                    if (!any_reg) begin
                        res_next.time_remaining = -33'sd1;
                    end else if (best_reg <= now_reg) begin
                        res_next.time_remaining = '0;
                    end else if (gap[47:32] != '0) begin
                        res_next.time_remaining = 33'h0FFFFFFFF;
                    end else begin
                        res_next.time_remaining = {1'b0, gap[31:0]};
                    end
                    idx_next = '0;
                    hit_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // slot payload
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dl_reg[wr_slot] <= wr_dl;
            iv_reg[wr_slot] <= cmd_reg.interval_ms;
            per_reg[wr_slot] <= cmd_reg.repeat_flag;
            id_reg[wr_slot] <= nid_reg + 32'd1;
            tg_reg[wr_slot] <= cmd_reg.user_tag;
        end else if (wr_dl_only) begin
            dl_reg[wr_slot] <= wr_dl;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        pick_reg <= pick_next;
        best_reg <= best_next;
        res_reg <= res_next;
        fired_reg <= fired_next;
        pend_reg <= pend_next;
        any_reg <= any_next;
        hit_reg <= hit_next;
        n_reg <= n_next;
        rem_done_reg <= rem_done_next;
        more_reg <= more_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            valid_reg <= '0;
            now_reg <= '0;
            nid_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            valid_reg <= valid_next;
            now_reg <= now_next;
            nid_reg <= nid_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/deadline_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Deadline timer queue with add, remove and millisecond tick requests.
// ----------------------------------------------------------------------------
// A two-entry request queue decouples the input from the sequencer. Each
// result takes a slot search over all MAX_TIMERS slots, one slot a cycle,
// an issue step, a scan of all slots for the earliest deadline and an
// output step; add and remove give one result, and a tick repeats these
// steps for each timer that it fires (once when nothing is due). A stalled
// result holds the sequencer before its next issue. Operation code 3 is
// dropped with no result.
`default_nettype none
module deadline_timer_queue_top
    import dtq_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // operation[1:0]
    input  wire  [1:0]   s_tuser,
    // interval_ms[31:0], repeat_flag[32], user_tag[64:33], target_id[96:65],
    // zero fill
    input  wire  [103:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // result_kind[2:0]
    output logic [2:0]   m_tuser,
    // timer_id[31:0], deadline[79:32], tag_out[111:80], time_remaining[144:112],
    // zero fill
    output logic [151:0] m_tdata,
    output logic         m_tlast
);
    cmd_t cmd, q_cmd;
    res_t res;
    logic q_valid, q_ready;

    assign cmd.operation = s_tuser;
    assign cmd.interval_ms = s_tdata[31:0];
    assign cmd.repeat_flag = s_tdata[32];
    assign cmd.user_tag = s_tdata[64:33];
    assign cmd.target_id = s_tdata[96:65];

    dtq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    dtq_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tuser = res.result_kind;
    assign m_tdata = {7'd0, res.time_remaining, res.tag_out, res.deadline,
                      res.timer_id};
    assign m_tlast = res.last;
endmodule
`default_nettype wire

/* tb/tb_deadline_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue_top
// Self-checking bench for the deadline timer queue: a predictor of the slot
// table works out the results of every accepted request and a scoreboard
// compares each returned result, in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class dtq_scoreboard;
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [47:0] dl;
        logic [31:0] tag;
        logic [32:0] rem;
        logic        lst;
    } dtq_res_s;

    bit          valid_q[dtq_pkg::MAX_TIMERS];
    logic [47:0] dl_q[dtq_pkg::MAX_TIMERS];
    logic [31:0] ival_q[dtq_pkg::MAX_TIMERS];
    bit          per_q[dtq_pkg::MAX_TIMERS];
    logic [31:0] id_q[dtq_pkg::MAX_TIMERS];
    logic [31:0] tag_q[dtq_pkg::MAX_TIMERS];
    logic [47:0] now_ms;
    logic [31:0] last_id;
    dtq_res_s    pending[$];
    int          errors;

    function new();
        foreach (valid_q[i]) valid_q[i] = 0;
        now_ms = 0;
        last_id = 0;
        errors = 0;
    endfunction

    function int occupied();
        int n;
        n = 0;
        foreach (valid_q[i]) if (valid_q[i]) n++;
        return n;
    endfunction

    function void report(string what, logic [154:0] got, logic [154:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endfunction

    function logic [32:0] time_left();
        bit          any;
        logic [47:0] best;
        logic [47:0] d;
        any = 0;
        best = 0;
        foreach (valid_q[i])
            if (valid_q[i] && (!any || dl_q[i] < best)) begin
                best = dl_q[i];
                any = 1;
            end
        if (!any) return '1;
        if (best <= now_ms) return 0;
        d = best - now_ms;
        return (d > 48'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, d[31:0]};
    endfunction

    // Note one accepted request ({tdata, tuser}) and queue the results it causes.
    function void note_request(logic [105:0] req);
        logic [1:0]  op;
        dtq_res_s    r;
        dtq_res_s    batch[$];
        bit          fired[dtq_pkg::MAX_TIMERS];
        int          hit;
        int          pick;
        logic [32:0] rem;
        op = req[1:0];
        hit = -1;
        r = '{0, 0, 0, 0, 0, 0};
        if (op == dtq_pkg::OP_ADD) begin
            foreach (valid_q[i]) if (!valid_q[i] && hit < 0) hit = i;
            if (hit < 0) begin
                r.kind = dtq_pkg::KIND_FULL;
            end else begin
                last_id++;
                valid_q[hit] = 1;
                dl_q[hit] = now_ms + req[33:2];
                ival_q[hit] = req[33:2];
                per_q[hit] = req[34];
                id_q[hit] = last_id;
                tag_q[hit] = req[66:35];
                r.kind = dtq_pkg::KIND_ADDED;
                r.id = last_id;
                r.dl = dl_q[hit];
            end
            batch.push_back(r);
        end else if (op == dtq_pkg::OP_REMOVE) begin
            foreach (valid_q[i])
                if (valid_q[i] && id_q[i] == req[98:67] && hit < 0) hit = i;
            r.kind = (hit < 0) ? dtq_pkg::KIND_NOT_FOUND : dtq_pkg::KIND_REMOVED;
            r.id = req[98:67];
            if (hit >= 0) valid_q[hit] = 0;
            batch.push_back(r);
        end else if (op == dtq_pkg::OP_TICK) begin
            foreach (fired[i]) fired[i] = 0;
            now_ms++;
            while (batch.size() < dtq_pkg::MAX_RESULTS) begin
                pick = -1;
                foreach (valid_q[i])
                    if (valid_q[i] && !fired[i] && dl_q[i] <= now_ms &&
                        (pick < 0 || dl_q[i] < dl_q[pick] ||
                         (dl_q[i] == dl_q[pick] && id_q[i] < id_q[pick])))
                        pick = i;
                if (pick < 0) break;
                fired[pick] = 1;
                r.kind = dtq_pkg::KIND_EXPIRED;
                r.id = id_q[pick];
                r.dl = dl_q[pick];
                r.tag = tag_q[pick];
                batch.push_back(r);
                if (per_q[pick]) dl_q[pick] = now_ms + ival_q[pick];
                else valid_q[pick] = 0;
            end
            if (batch.size() == 0) begin
                r.kind = dtq_pkg::KIND_IDLE;
                batch.push_back(r);
            end
        end
        // Unknown operation: drop with no result.
        if (batch.size() == 0) return;
        rem = time_left();
        foreach (batch[k]) begin
            batch[k].rem = rem;
            batch[k].lst = (k == batch.size() - 1);
            pending.push_back(batch[k]);
        end
    endfunction

    // Compare one returned result ({tdata, tuser}) with the oldest expectation.
    function void check_result(logic [154:0] data, logic lst);
        dtq_res_s e;
        if (pending.size() == 0) begin
            report("unexpected result", data, 0);
            return;
        end
        e = pending.pop_front();
        if (data[2:0] != e.kind) report("result_kind", data[2:0], e.kind);
        if (data[34:3] != e.id) report("timer_id", data[34:3], e.id);
        if (data[82:35] != e.dl) report("deadline", data[82:35], e.dl);
        if (data[114:83] != e.tag) report("tag_out", data[114:83], e.tag);
        if (data[147:115] != e.rem) report("time_remaining", data[147:115], e.rem);
        if (data[154:148] != 0) report("zero fill", data[154:148], 0);
        if (lst != e.lst) report("tlast", lst, e.lst);
    endfunction
endclass

module tb_deadline_timer_queue_top;
    import dtq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [1:0]   s_tuser = 0;
    logic [103:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [2:0]   m_tuser;
    logic [151:0] m_tdata;
    logic         m_tlast;

    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    bit stim_done = 0;
    dtq_scoreboard timer_book = new();

    deadline_timer_queue_top dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            timer_book.note_request({s_tdata, s_tuser});
        if (aresetn && m_tvalid && m_tready)
            timer_book.check_result({m_tdata, m_tuser}, m_tlast);
    end

    // Receiver: stall at random at the falling edge.
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= dst_stall_pct);

    function automatic logic [105:0] pack_request(logic [1:0] op, logic [31:0] ival,
                                                  logic rep, logic [31:0] tag,
                                                  logic [31:0] tid);
        return {7'd0, tid, tag, rep, ival, op};
    endfunction

    // Offer one request, idling first at random, and hold until accepted.
    task automatic send_request(logic [105:0] req);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req[1:0];
        s_tdata <= req[105:2];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (timer_book.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // Random request biased towards a lively table.
    task automatic random_request();
        int          pick;
        logic [31:0] ival;
        logic [31:0] tid;
        pick = $urandom_range(99);
        case ($urandom_range(5))
            0: ival = $urandom;
            1: ival = 0;
            default: ival = $urandom_range(6);
        endcase
        tid = ($urandom_range(3) == 0) ? $urandom : timer_book.last_id - $urandom_range(8);
        if (pick < 40 && timer_book.occupied() < MAX_TIMERS - 2 || pick < 5)
            send_request(pack_request(OP_ADD, ival, 1'($urandom), $urandom, tid));
        else if (pick < 55)
            send_request(pack_request(OP_REMOVE, ival, 1'($urandom), $urandom, tid));
        else if (pick < 97)
            send_request(pack_request(OP_TICK, $urandom, 1'($urandom), $urandom,
                                      $urandom));
        else
            send_request(pack_request(OP_UNUSED, $urandom, 1'($urandom), $urandom,
                                      $urandom));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: extremes, every operation, full table, ties, interval zero.
        send_request(pack_request(OP_TICK, '1, 1, '1, '1));
        send_request(pack_request(OP_ADD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0));
        send_request(pack_request(OP_ADD, 0, 1, 32'hA5A5_5A5A, '1));
        send_request(pack_request(OP_TICK, 0, 0, 0, 0));
        send_request(pack_request(OP_TICK, 0, 0, 0, 0));
        send_request(pack_request(OP_REMOVE, 0, 0, 0, 2));
        send_request(pack_request(OP_REMOVE, 0, 0, 0, 2));
        send_request(pack_request(OP_REMOVE, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(pack_request(OP_UNUSED, '1, 1, '1, '1));
        for (int i = 0; i < 15; i++)
            send_request(pack_request(OP_ADD, 1, i[0], i, 0));
        send_request(pack_request(OP_ADD, 5, 0, 0, 0));
        send_request(pack_request(OP_TICK, 0, 0, 0, 0));
        send_request(pack_request(OP_TICK, 0, 0, 0, 0));
        // Hold off until every expected result is back.
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 22) : 0;
            dst_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 59 : 22) : 0;
            for (int n = 0; n < 75; n++) random_request();
        end
        s_tvalid <= 0;
        src_idle_pct = 0;
        stim_done = 1;
    end

    // Finish once stimulus is done and every result is back.
    initial begin
        wait (stim_done);
        while (timer_book.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (timer_book.errors == 0 && timer_book.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
